// File: rtl/core/ywu_pkg.sv
// ----------------------------------------------------------------------------
// ywu_pkg: shared types and constants for the yaw unwrap unit
// Configuration register indexes, angle constants and the radian scale.
// ----------------------------------------------------------------------------
package ywu_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned LIMIT_W   = 16;
  localparam int unsigned RAW_W     = 17;
  localparam int unsigned DEG_W     = 32;
  localparam int unsigned RAD_W     = 35;
  localparam int unsigned SCALE_W   = 27;
  localparam int unsigned PROD_W    = DEG_W + SCALE_W;
  localparam int unsigned RAD_SHIFT = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_PASS_BAND_LIMIT = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_FLIP_SUM_LIMIT  = cfg_idx_t'(1);

  localparam logic [LIMIT_W-1:0] PASS_BAND_RESET = 16'd10240;
  localparam logic [LIMIT_W-1:0] FLIP_SUM_RESET  = 16'd7680;

  // 19-bit signed working width for sample differences
  localparam logic signed [18:0] HALF_TURN = 19'sd46080;
  localparam logic signed [18:0] FULL_TURN = 19'sd92160;

  localparam logic signed [RAW_W-1:0] SAMPLE_MAX = 17'sd65535;
  localparam logic signed [RAW_W-1:0] SAMPLE_MIN = -17'sd65536;

  // 256*pi/180 in unsigned Q24
  localparam logic [SCALE_W-1:0] RAD_SCALE = 27'd74961321;

  localparam logic [PROD_W-1:0] RAD_ROUND = PROD_W'(1) << (RAD_SHIFT - 1);

  localparam logic signed [DEG_W:0] ACC_MAX = 33'sd2147483647;
  localparam logic signed [DEG_W:0] ACC_MIN = -33'sd2147483648;

endpackage

// File: rtl/core/yaw_unwrap_with_flip_fix_unit.sv
// ----------------------------------------------------------------------------
// yaw_unwrap_with_flip_fix_unit: continuous yaw from raw wrapped samples
// Flip repair, +-180 degree wrap, saturating accumulation, radian output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one raw yaw word per cycle in
//   1/256 degree. Result channel (out_valid/out_ready) gives one word per
//   input: unwrapped yaw in 1/256 degree, in 1/65536 radian, and a flag set
//   when the accumulator clipped at its 32-bit limit on that sample.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   pass_band_limit (index 0) and flip_sum_limit (index 1); other indexes
//   are ignored. cfg_ready is always high; write only while idle.
//   The unwrap/accumulate step registers into stage 1 (acc_r) and feeds a
//   two-stage 32x27 radian multiply and rounding pipeline (stages 2 and 3).
//   Throughput: one word per cycle while out_ready is high.
//   Reset clears the unwrap state (the next sample seeds it) and loads the
//   limit registers with 40 and 30 degrees. When out_ready is low the
//   pipeline keeps filling its empty stages, then drops in_ready.
// ----------------------------------------------------------------------------
module yaw_unwrap_with_flip_fix_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [ywu_pkg::RAW_W-1:0]    in_raw_yaw,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ywu_pkg::DEG_W-1:0]    out_yaw_degrees,
  output logic signed [ywu_pkg::RAD_W-1:0]    out_yaw_radians,
  output logic                                out_saturated,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  ywu_pkg::cfg_idx_t                   cfg_index,
  input  logic [ywu_pkg::LIMIT_W-1:0]         cfg_data
);

  logic [ywu_pkg::LIMIT_W-1:0] pass_lim_r;
  logic [ywu_pkg::LIMIT_W-1:0] flip_lim_r;

  logic                               seen_first_r;
  logic signed [ywu_pkg::RAW_W-1:0]   prev_r;
  logic signed [ywu_pkg::DEG_W-1:0]   acc_r;

  logic                               s1_v_r, s2_v_r, s3_v_r;
  logic                               s1_sat_r, s2_sat_r, s3_sat_r;
  logic signed [ywu_pkg::DEG_W-1:0]   s2_deg_r, s3_deg_r;
  logic                               s2_neg_r;
  logic [ywu_pkg::PROD_W-1:0]         s2_prod_r;
  logic signed [ywu_pkg::RAD_W-1:0]   s3_rad_r;

  logic rdy1, rdy2, rdy3, in_acc;

  // unwrap datapath
  logic signed [17:0]                 raw_e, lim_e, sum_e;
  logic [18:0]                        sum_mag;
  logic                               in_band, do_flip;
  logic signed [ywu_pkg::RAW_W-1:0]   neg_raw, used;
  logic signed [18:0]                 delta0, delta1, delta2;
  logic signed [ywu_pkg::DEG_W:0]     acc_sum;
  logic signed [ywu_pkg::DEG_W-1:0]   acc_nxt;
  logic                               sat_nxt;
  logic signed [ywu_pkg::RAW_W-1:0]   prev_nxt;

  // radian datapath
  logic [ywu_pkg::DEG_W:0]            mag_wide;
  logic [ywu_pkg::DEG_W-1:0]          mag;
  logic [ywu_pkg::PROD_W-1:0]         prod_nxt, rnd;
  logic signed [ywu_pkg::RAD_W-1:0]   rad_mag, rad_nxt;

  function automatic logic s1_deg_neg();
    return acc_r[ywu_pkg::DEG_W-1];
  endfunction

  assign rdy3     = !s3_v_r || out_ready;
  assign rdy2     = !s2_v_r || rdy3;
  assign rdy1     = !s1_v_r || rdy2;
  assign in_ready = rdy1;
  assign in_acc   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    raw_e   = 18'(in_raw_yaw);
    lim_e   = $signed({2'b00, pass_lim_r});
    in_band = (raw_e > -lim_e) && (raw_e < lim_e);
    sum_e   = raw_e + 18'(prev_r);
    sum_mag = sum_e[17] ? 19'(-19'(sum_e)) : 19'(sum_e);
    do_flip = !in_band && (sum_mag <= {3'b000, flip_lim_r});
    neg_raw = (in_raw_yaw == ywu_pkg::SAMPLE_MIN) ? ywu_pkg::SAMPLE_MAX : -in_raw_yaw;
    used    = do_flip ? neg_raw : in_raw_yaw;
    delta0  = 19'(used) - 19'(prev_r);
    delta1  = (delta0 > ywu_pkg::HALF_TURN) ? delta0 - ywu_pkg::FULL_TURN : delta0;
    delta2  = (delta1 < -ywu_pkg::HALF_TURN) ? delta1 + ywu_pkg::FULL_TURN : delta1;
    acc_sum = 33'(acc_r) + 33'(delta2);
    if (!seen_first_r) begin
      acc_nxt  = 32'(in_raw_yaw);
      prev_nxt = in_raw_yaw;
      sat_nxt  = 1'b0;
    end else begin
      prev_nxt = used;
      if (acc_sum > ywu_pkg::ACC_MAX) begin
        acc_nxt = ywu_pkg::ACC_MAX[ywu_pkg::DEG_W-1:0];
        sat_nxt = 1'b1;
      end else if (acc_sum < ywu_pkg::ACC_MIN) begin
        acc_nxt = ywu_pkg::ACC_MIN[ywu_pkg::DEG_W-1:0];
        sat_nxt = 1'b1;
      end else begin
        acc_nxt = acc_sum[ywu_pkg::DEG_W-1:0];
        sat_nxt = 1'b0;
      end
    end
  end

  always_comb begin
    mag_wide = s1_deg_neg() ? 33'(-33'(acc_r)) : 33'(acc_r);
    mag      = mag_wide[ywu_pkg::DEG_W-1:0];
    prod_nxt = ywu_pkg::PROD_W'(mag) * ywu_pkg::PROD_W'(ywu_pkg::RAD_SCALE);
    rnd      = s2_prod_r + ywu_pkg::RAD_ROUND;
    rad_mag  = $signed(rnd[ywu_pkg::RAD_SHIFT +: ywu_pkg::RAD_W]);
    rad_nxt  = s2_neg_r ? -rad_mag : rad_mag;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_lim_r <= ywu_pkg::PASS_BAND_RESET;
      flip_lim_r <= ywu_pkg::FLIP_SUM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ywu_pkg::CFG_PASS_BAND_LIMIT: pass_lim_r <= cfg_data;
        ywu_pkg::CFG_FLIP_SUM_LIMIT:  flip_lim_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // unwrap state and stage 1 (acc_r doubles as the stage 1 degree word)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_first_r <= 1'b0;
      prev_r       <= '0;
      acc_r        <= '0;
      s1_v_r       <= 1'b0;
    end else begin
      if (in_acc) begin
        seen_first_r <= 1'b1;
        prev_r       <= prev_nxt;
        acc_r        <= acc_nxt;
      end
      if (rdy1) begin
        s1_v_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sat_r <= sat_nxt;
    end
  end

  // stage 2: magnitude times scale
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (rdy2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && s1_v_r) begin
      s2_deg_r  <= acc_r;
      s2_neg_r  <= s1_deg_neg();
      s2_prod_r <= prod_nxt;
      s2_sat_r  <= s1_sat_r;
    end
  end

  // stage 3: round, sign, output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (rdy3) begin
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && s2_v_r) begin
      s3_deg_r <= s2_deg_r;
      s3_rad_r <= rad_nxt;
      s3_sat_r <= s2_sat_r;
    end
  end

  assign out_valid       = s3_v_r;
  assign out_yaw_degrees = s3_deg_r;
  assign out_yaw_radians = s3_rad_r;
  assign out_saturated   = s3_sat_r;

endmodule
